>>> rtl/core/separable_blur_5tap_rgb_defines.svh
// Assertion macros shared by the blur RTL.
`ifndef SEPARABLE_BLUR_5TAP_RGB_DEFINES_SVH
`define SEPARABLE_BLUR_5TAP_RGB_DEFINES_SVH

// Condition and consequence checked in the same cycle.
`define SBLUR_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequence checked in the cycle after the condition.
`define SBLUR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/sblur_pkg.sv
// Types, constants and arithmetic helpers of the separable 5x5 blur.
`timescale 1ns / 1ps
`default_nettype none

package sblur_pkg;

   localparam int MAX_WIDTH      = 1024;
   localparam int MIN_DIM        = 5;
   localparam int CFG_WIDTH_W    = 11;
   localparam int CFG_HEIGHT_W   = 12;
   localparam int COL_W          = $clog2(MAX_WIDTH);
   localparam int ROW_W          = CFG_HEIGHT_W;
   localparam int WCMP_W         = (CFG_WIDTH_W > COL_W + 1) ? CFG_WIDTH_W : COL_W + 1;
   localparam int LINE_COUNT     = 4;
   localparam int SLOT_W         = $clog2(LINE_COUNT);
   localparam int COL_TAPS       = 4;
   localparam int CHAN_W         = 8;
   localparam int PIX_W          = 3 * CHAN_W;
   localparam int SUM_W          = 12;
   localparam int RESULT_START   = 2;
   localparam int INTERIOR_START = 4;
   localparam int CSR_IDX_W      = 1;
   localparam int CSR_DATA_W     = 12;

   // Reciprocal of ten in 16 fractional bits, exact for sums up to 2550.
   localparam logic [12:0] RECIP_10    = 13'd6554;
   localparam int          RECIP_SHIFT = 16;
   localparam int          PROD_W      = SUM_W + 13;

   localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = CFG_WIDTH_W'(640);
   localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = CFG_HEIGHT_W'(480);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic emit;
      logic interior;
      logic last;
   } flags_type;

   function automatic logic [CHAN_W-1:0] div10(input logic [SUM_W-1:0] s);
      logic [PROD_W-1:0] p;
      p = PROD_W'(s) * PROD_W'(RECIP_10);
      return p[RECIP_SHIFT +: CHAN_W];
   endfunction

   function automatic logic [CHAN_W-1:0] tap_chan(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b,
                                                  input logic [CHAN_W-1:0] m,
                                                  input logic [CHAN_W-1:0] d,
                                                  input logic [CHAN_W-1:0] e);
      logic [SUM_W-1:0] s;
      s = {4'b0, a} + {3'b0, b, 1'b0} + {2'b0, m, 2'b0} + {3'b0, d, 1'b0} + {4'b0, e};
      return div10(s);
   endfunction

   // Weights 1,2,4,2,1 over five pixels, oldest first, per channel.
   function automatic pixel_type tap5(input pixel_type a, input pixel_type b,
                                      input pixel_type m, input pixel_type d,
                                      input pixel_type e);
      pixel_type r;
      r.blue  = tap_chan(a.blue,  b.blue,  m.blue,  d.blue,  e.blue);
      r.green = tap_chan(a.green, b.green, m.green, d.green, e.green);
      r.red   = tap_chan(a.red,   b.red,   m.red,   d.red,   e.red);
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/sblur_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module sblur_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/separable_blur_5tap_rgb.sv
// Top level of the streaming separable 5x5 blur for RGB pixels, weights 1,2,4,2,1.
`timescale 1ns / 1ps
`default_nettype none
//
// Pixels arrive in raster order on the req_ channel, one word per pixel.
// For each pixel taken at row y, column x, the blurred pixel at y-2, x-2 is
// produced on the rsp_ channel once y and x are both at least two; earlier
// pixels of a row or frame produce no word. A border result carries zero
// channels with tuser low, and tlast marks the result of the last pixel of
// a frame. The user writes frame width and height over the csr_ channel only
// while the block is idle; the block itself does not enforce this.
// One word is taken every cycle while req_tready is high. The edge that takes
// a pixel also starts the line store read; after that the vertical pass is
// registered and then the horizontal pass is loaded into the result register.
// The rate is one pixel per cycle while nothing stalls, because a line RAM can
// take a read and a write in the same cycle.
// Reset clears the counters, the pipeline and the column taps and sets the
// frame to 640 by 480; the line store holds no defined data and needs no
// clearing. While rsp_tready is low the result word holds, words keep
// moving into empty stages, and req_tready falls once the stages are full.

`include "separable_blur_5tap_rgb_defines.svh"

module separable_blur_5tap_rgb (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // blue_in [7:0], green_in [15:8], red_in [23:16]
   input  logic [sblur_pkg::PIX_W-1:0]      req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // blue_out [7:0], green_out [15:8], red_out [23:16]
   output logic [sblur_pkg::PIX_W-1:0]      rsp_tdata,
   // interior [0]
   output logic                             rsp_tuser,
   output logic                             rsp_tlast,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sblur_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sblur_pkg::CSR_DATA_W-1:0] csr_data
);

   import sblur_pkg::*;

   logic [CFG_WIDTH_W-1:0]  frame_width_ff;
   logic [CFG_HEIGHT_W-1:0] frame_height_ff;
   logic [COL_W-1:0]        col_ff;
   logic [ROW_W-1:0]        row_ff;

   logic [WCMP_W-1:0]       fw_ext;
   logic [WCMP_W-1:0]       w_eff;
   logic [ROW_W-1:0]        h_eff;
   logic [COL_W-1:0]        col_cur;
   logic [ROW_W-1:0]        row_cur;
   logic [WCMP_W-1:0]       col_inc;
   logic [ROW_W:0]          row_inc;
   logic                    last_col;
   logic                    last_row;
   logic [COL_W-1:0]        col_in;
   logic [ROW_W-1:0]        row_in;
   flags_type               flags_in;

   logic                    accept;
   logic                    en_out;
   logic                    en2;
   logic                    en1;

   logic                    s1_v_ff;
   pixel_type               s1_px_ff;
   logic [COL_W-1:0]        s1_col_ff;
   logic [SLOT_W-1:0]       s1_slot_ff;
   flags_type               s1_flags_ff;
   logic                    wr_pend_ff;

   logic [PIX_W-1:0]        ram_rd [LINE_COUNT];
   logic [SLOT_W-1:0]       idx_b;
   logic [SLOT_W-1:0]       idx_m;
   logic [SLOT_W-1:0]       idx_d;
   pixel_type               vert_in;

   logic                    s2_v_ff;
   flags_type               s2_flags_ff;
   pixel_type               vert_ff;
   pixel_type               col_sh_ff [COL_TAPS];
   pixel_type               horiz_in;

   logic                    rsp_v_ff;
   pixel_type               rsp_px_ff;
   logic                    rsp_interior_ff;
   logic                    rsp_last_ff;

   // Register writes.
   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= WIDTH_RESET;
         frame_height_ff <= HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data[CFG_WIDTH_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_data[CFG_HEIGHT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Clamped frame size and raster position of the arriving pixel.
   always_comb begin
      fw_ext = WCMP_W'(frame_width_ff);
      if (fw_ext < WCMP_W'(MIN_DIM)) begin
         w_eff = WCMP_W'(MIN_DIM);
      end else if (fw_ext > WCMP_W'(MAX_WIDTH)) begin
         w_eff = WCMP_W'(MAX_WIDTH);
      end else begin
         w_eff = fw_ext;
      end
      h_eff   = (frame_height_ff < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : frame_height_ff;
      col_cur = (WCMP_W'(col_ff) >= w_eff) ? '0 : col_ff;
      row_cur = (row_ff >= h_eff) ? '0 : row_ff;
      col_inc  = WCMP_W'(col_cur) + WCMP_W'(1);
      row_inc  = {1'b0, row_cur} + (ROW_W + 1)'(1);
      last_col = col_inc >= w_eff;
      last_row = row_inc >= {1'b0, h_eff};
      col_in   = last_col ? '0 : col_inc[COL_W-1:0];
      if (last_col) begin
         row_in = last_row ? '0 : row_inc[ROW_W-1:0];
      end else begin
         row_in = row_cur;
      end
      flags_in.emit     = (row_cur >= ROW_W'(RESULT_START)) &&
                          (col_cur >= COL_W'(RESULT_START));
      flags_in.interior = (row_cur >= ROW_W'(INTERIOR_START)) &&
                          (col_cur >= COL_W'(INTERIOR_START));
      flags_in.last     = last_col && last_row;
   end

   // Stage enables: a stage moves on when the one after it has room.
   assign en_out     = !rsp_v_ff || rsp_tready;
   assign en2        = !s2_v_ff || !s2_flags_ff.emit || en_out;
   assign en1        = !s1_v_ff || en2;
   assign req_tready = en1 && !reset;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         s1_v_ff    <= 1'b0;
         wr_pend_ff <= 1'b0;
      end else begin
         wr_pend_ff <= accept;
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (en1) begin
            s1_v_ff <= accept;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff    <= req_tdata;
         s1_col_ff   <= col_cur;
         s1_slot_ff  <= row_cur[SLOT_W-1:0];
         s1_flags_ff <= flags_in;
      end
   end

   // Four line RAMs; the slot of the current row holds the oldest line and is
   // overwritten by the new pixel in the cycle after it is read.
   genvar g;
   for (g = 0; g < LINE_COUNT; g++) begin : g_line
      sblur_ram #(
         .WIDTH (PIX_W),
         .DEPTH (MAX_WIDTH)
      ) u_line (
         .clock   (clock),
         .wr_en   (wr_pend_ff && (s1_slot_ff == SLOT_W'(g))),
         .wr_addr (s1_col_ff),
         .wr_data (s1_px_ff),
         .rd_en   (accept),
         .rd_addr (col_cur),
         .rd_data (ram_rd[g])
      );
   end

   // Vertical pass over rows y-4 .. y.
   always_comb begin
      idx_b   = s1_slot_ff + SLOT_W'(3);
      idx_m   = s1_slot_ff + SLOT_W'(2);
      idx_d   = s1_slot_ff + SLOT_W'(1);
      vert_in = tap5(ram_rd[s1_slot_ff], ram_rd[idx_b], ram_rd[idx_m], ram_rd[idx_d],
                     s1_px_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
         vert_ff <= '0;
         for (int i = 0; i < COL_TAPS; i++) begin
            col_sh_ff[i] <= '0;
         end
      end else if (en2) begin
         s2_v_ff <= s1_v_ff;
         if (s1_v_ff) begin
            vert_ff      <= vert_in;
            col_sh_ff[0] <= vert_ff;
            for (int i = 1; i < COL_TAPS; i++) begin
               col_sh_ff[i] <= col_sh_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en2 && s1_v_ff) begin
         s2_flags_ff <= s1_flags_ff;
      end
   end

   // Horizontal pass over columns x-4 .. x.
   assign horiz_in = tap5(col_sh_ff[3], col_sh_ff[2], col_sh_ff[1], col_sh_ff[0], vert_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (en_out) begin
         rsp_v_ff <= s2_v_ff && s2_flags_ff.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         rsp_px_ff       <= s2_flags_ff.interior ? horiz_in : '0;
         rsp_interior_ff <= s2_flags_ff.interior;
         rsp_last_ff     <= s2_flags_ff.last;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_px_ff;
   assign rsp_tuser  = rsp_interior_ff;
   assign rsp_tlast  = rsp_last_ff;

   `SBLUR_ASSERT_SAME(a_border_zero, rsp_tvalid && !rsp_tuser, rsp_tdata == '0, "border word carries data")
   `SBLUR_ASSERT_SAME(a_last_interior, rsp_tvalid && rsp_tlast, rsp_tuser, "frame end word not interior")
   `SBLUR_ASSERT_NEXT(a_col_range, accept, WCMP_W'(col_ff) < $past(w_eff), "column beyond width")
   `SBLUR_ASSERT_SAME(a_line_hazard, wr_pend_ff && accept, s1_col_ff != col_cur, "line read meets write")

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the streaming separable 5x5 RGB blur.
`timescale 1ns / 1ps

module tb;
   import sblur_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 12;
   localparam int RANDOM_PIXELS = 700;
   localparam int HOLD_AFTER    = 20;
   localparam int HOLD_CYCLES   = 400;

   typedef struct packed {
      logic      last;
      logic      interior;
      pixel_type pix;
   } blurred_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   pixel_type             req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   pixel_type             rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   csr_reg_type           csr_index = CSR_FRAME_WIDTH;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   separable_blur_5tap_rgb dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   // Shadow state of the filter.
   pixel_type                line_mem [4][MAX_WIDTH];
   pixel_type                col_taps [4];
   int                       col_cnt = 0;
   int                       row_cnt = 0;
   logic [CFG_WIDTH_W-1:0]   cfg_width = WIDTH_RESET;
   logic [CFG_HEIGHT_W-1:0]  cfg_height = HEIGHT_RESET;

   pixel_type        pixel_q [$];
   blurred_word_type blurred_q [$];

   int   pixels_queued = 0;
   int   pixels_taken = 0;
   int   rsp_words = 0;
   int   interior_words = 0;
   int   frame_ends = 0;
   int   fault_count = 0;
   int   cycle_count = 0;
   int   settings_used = 0;
   logic req_taken = 1'b0;
   logic steady_feed = 1'b0;
   int   burst_left = 0;
   int   gap_left = 0;
   int   hold_left = 0;
   logic hold_done = 1'b0;
   logic [15:0] ready_bits = 16'hFFFF;
   logic [6:0]  pattern_age = '0;

   function automatic int effective_width();
      int w;
      w = int'(cfg_width);
      if (w < MIN_DIM) w = MIN_DIM;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      return w;
   endfunction

   function automatic int effective_height();
      int h;
      h = int'(cfg_height);
      if (h < MIN_DIM) h = MIN_DIM;
      return h;
   endfunction

   function automatic logic [CHAN_W-1:0] binomial5(input logic [CHAN_W-1:0] a, b, m, d, e);
      int s;
      s = a + 2 * b + 4 * m + 2 * d + e;
      return CHAN_W'(s / 10);
   endfunction

   function automatic pixel_type binomial5_px(input pixel_type a, b, m, d, e);
      pixel_type r;
      r.blue  = binomial5(a.blue, b.blue, m.blue, d.blue, e.blue);
      r.green = binomial5(a.green, b.green, m.green, d.green, e.green);
      r.red   = binomial5(a.red, b.red, m.red, d.red, e.red);
      return r;
   endfunction

   function automatic int pixels_left_in_frame();
      int w, h, c, r;
      w = effective_width();
      h = effective_height();
      c = (col_cnt >= w) ? 0 : col_cnt;
      r = (row_cnt >= h) ? 0 : row_cnt;
      return (h - r) * w - c;
   endfunction

   task automatic blur_take_pixel(input pixel_type px);
      int w, h, col, row;
      pixel_type vert, horiz;
      blurred_word_type res;
      w = effective_width();
      h = effective_height();
      if (col_cnt >= w) col_cnt = 0;
      if (row_cnt >= h) row_cnt = 0;
      col = col_cnt;
      row = row_cnt;
      vert = binomial5_px(line_mem[row % 4][col], line_mem[(row + 3) % 4][col],
                          line_mem[(row + 2) % 4][col], line_mem[(row + 1) % 4][col], px);
      horiz = binomial5_px(col_taps[3], col_taps[2], col_taps[1], col_taps[0], vert);
      line_mem[row % 4][col] = px;
      col_taps[3] = col_taps[2];
      col_taps[2] = col_taps[1];
      col_taps[1] = col_taps[0];
      col_taps[0] = vert;
      if (row >= 2 && col >= 2) begin
         res.interior = (row >= 4 && col >= 4);
         res.pix = res.interior ? horiz : '0;
         res.last = (row == h - 1 && col == w - 1);
         blurred_q.insert(blurred_q.size(), res);
      end
      if (col + 1 >= w) begin
         col_cnt = 0;
         row_cnt = (row + 1 >= h) ? 0 : row + 1;
      end else begin
         col_cnt = col + 1;
      end
   endtask

   function automatic void note_fault(input string msg);
      fault_count++;
      if (fault_count <= 10) $display("mismatch: %s", msg);
   endfunction

   task automatic write_csr(input csr_reg_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_FRAME_WIDTH) cfg_width = value[CFG_WIDTH_W-1:0];
      else cfg_height = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_frame(input logic [CSR_DATA_W-1:0] w, input logic [CSR_DATA_W-1:0] h);
      write_csr(CSR_FRAME_WIDTH, w);
      write_csr(CSR_FRAME_HEIGHT, h);
      settings_used++;
   endtask

   task automatic queue_random_pixels(input int n);
      pixel_type px;
      for (int i = 0; i < n; i++) begin
         px = PIX_W'($urandom_range(0, 24'hFFFFFF));
         pixel_q.insert(pixel_q.size(), px);
         pixels_queued++;
      end
   endtask

   task automatic wait_idle();
      do @(negedge clock); while (pixels_taken != pixels_queued || blurred_q.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Pixel source: bursts of random length separated by random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (gap_left > 0 && !steady_feed) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pixel_q.size() > 0) begin
            req_tdata <= pixel_q.pop_front();
            req_tvalid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 40);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result sink: a rotating stall pattern, renewed each time the 7-bit pattern_age wraps, and one long hold-off.
   always @(negedge clock) begin
      if (!hold_done && rsp_words >= HOLD_AFTER) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ready_bits[0];
         ready_bits = {ready_bits[0], ready_bits[15:1]};
         pattern_age++;
         if (pattern_age == 0) begin
            case ($urandom_range(0, 3))
               0: ready_bits = 16'hFFFF;
               1: ready_bits = 16'($urandom);
               2: ready_bits = 16'hAAAA;
               default: ready_bits = 16'($urandom) | 16'($urandom);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      blurred_word_type want;
      pixel_type got;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            blur_take_pixel(req_tdata);
            pixels_taken++;
            req_taken = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_words++;
            if (blurred_q.size() == 0) begin
               note_fault($sformatf("result word %0d arrived with nothing expected", rsp_words));
            end else begin
               want = blurred_q.pop_front();
               got = rsp_tdata;
               if (got.blue !== want.pix.blue || got.green !== want.pix.green ||
                   got.red !== want.pix.red || rsp_tuser !== want.interior ||
                   rsp_tlast !== want.last)
                  note_fault({$sformatf("word %0d expected b=%0d g=%0d r=%0d int=%0b last=%0b",
                                        rsp_words, want.pix.blue, want.pix.green,
                                        want.pix.red, want.interior, want.last),
                              $sformatf(", got b=%0d g=%0d r=%0d int=%0b last=%0b",
                                        got.blue, got.green, got.red, rsp_tuser,
                                        rsp_tlast)});
               if (want.interior) interior_words++;
               if (want.last) frame_ends++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("run stopped at the cycle limit with %0d words outstanding", blurred_q.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      int random_pixels;
      int n, w, h;
      pixel_type px;
      for (int s = 0; s < 4; s++) begin
         col_taps[s] = '0;
         for (int c = 0; c < MAX_WIDTH; c++) line_mem[s][c] = '0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Smallest frame: edge columns, border words, the single interior word and frame end.
      set_frame(CSR_DATA_W'(5), CSR_DATA_W'(5));
      for (int i = 0; i < 25; i++) begin
         px.blue = 8'hFF;
         px.green = (i % 2 != 0) ? 8'hFF : 8'h00;
         px.red = 8'(i * 10);
         pixel_q.insert(pixel_q.size(), px);
         pixels_queued++;
      end
      wait_idle();

      // Oversized width clamps to the largest line: one full row and a few pixels more.
      set_frame(12'hFFF, 12'd3);
      queue_random_pixels(MAX_WIDTH + 8);
      wait_idle();

      // Tallest frame, left part way down, then a height below the current row.
      set_frame(12'd0, 12'hFFF);
      queue_random_pixels(5 * 13);
      wait_idle();
      set_frame(12'd4, 12'd7);
      steady_feed = 1'b1;
      queue_random_pixels(pixels_left_in_frame());
      wait_idle();

      random_pixels = 0;
      while (random_pixels < RANDOM_PIXELS) begin
         if (col_cnt == 0 && row_cnt == 0)
            w = ($urandom_range(0, 5) == 0) ? $urandom_range(25, 64) : $urandom_range(5, 24);
         else
            w = $urandom_range(5, effective_width());
         h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 10);
         set_frame(CSR_DATA_W'(w), CSR_DATA_W'(h));
         steady_feed = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 3))
            0: n = $urandom_range(1, 3 * effective_width());
            1: n = pixels_left_in_frame() + effective_width() * effective_height();
            default: n = pixels_left_in_frame();
         endcase
         queue_random_pixels(n);
         random_pixels += n;
         wait_idle();
      end

      $display("covered %0d pixels over %0d frame settings,", pixels_taken, settings_used);
      $display("widths 5 to %0d and heights 5 to 4095", MAX_WIDTH);
      $display("checked %0d result words: %0d interior, %0d frame ends, %0d faults",
               rsp_words, interior_words, frame_ends, fault_count);
      if (fault_count == 0 && blurred_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
